// ===== src/tga_pkg.sv =====
// Shared types and codes for the TGA true-colour decoder.
// Used by every module in src; no dependencies of its own.
package tga_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } feed_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  span_count;
    logic [15:0] dest_row;
    logic [15:0] dest_column;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;
  } result_item_t;

  // command passed from the parser to the span placer
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  span_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] area;
    logic        top_down;
    logic        last;
  } cmd_t;

  localparam logic [1:0] KIND_SPAN   = 2'd0;
  localparam logic [1:0] KIND_HDR_OK = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_PACKET = 3'd3;
  localparam logic [2:0] PH_COLOUR = 3'd4;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] BPP_24   = 8'd24;
  localparam logic [7:0] BPP_32   = 8'd32;
  localparam logic [4:0] HDR_LAST = 5'd17;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

// ===== src/tga_front.sv =====
// Byte parser: header, ID skip, packet headers and colour gathering.
// Emits one tga_pkg::cmd_t per header result or completed pixel colour.
module tga_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  tga_pkg::feed_item_t feed,
  output logic                push,
  output tga_pkg::cmd_t       cmd
);

  logic [2:0]  phase, phase_next;
  logic [4:0]  hcnt, hcnt_next;
  logic [7:0]  id_skip, id_skip_next;
  logic [7:0]  image_kind, image_kind_next;
  logic [7:0]  palette_kind, palette_kind_next;
  logic [7:0]  bpp, bpp_next;
  logic        top_down, top_down_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] area;
  logic        is_run, is_run_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  cidx, cidx_next;
  logic [15:0] gather, gather_next;
  // red byte of a 32-bit pixel arrives before alpha
  logic [7:0]  red_hold;

  always_comb begin
    logic [2:0] ph;
    logic [4:0] hc;
    logic [7:0] b;
    logic       need4;
    logic       bad;
    logic       empty;
    ph = feed.start_of_file ? tga_pkg::PH_HEADER : phase;
    hc = feed.start_of_file ? 5'd0 : hcnt;
    b  = feed.data_byte;
    need4 = (bpp == tga_pkg::BPP_32);
    bad = ((image_kind != tga_pkg::TYPE_RAW) && (image_kind != tga_pkg::TYPE_RLE)) ||
          (palette_kind != 8'd0) ||
          ((bpp != tga_pkg::BPP_24) && (bpp != tga_pkg::BPP_32));
    empty = (width_reg == 16'd0) || (height_reg == 16'd0);
    phase_next = phase;
    hcnt_next = hcnt;
    id_skip_next = id_skip;
    image_kind_next = image_kind;
    palette_kind_next = palette_kind;
    bpp_next = bpp;
    top_down_next = top_down;
    width_reg_next = width_reg;
    height_reg_next = height_reg;
    is_run_next = is_run;
    packet_left_next = packet_left;
    cidx_next = cidx;
    gather_next = gather;
    push = 1'b0;
    cmd = '0;
    cmd.area = area;
    cmd.top_down = top_down_next;
    if (take) begin
      phase_next = ph;
      case (ph)
        tga_pkg::PH_HEADER: begin
          case (hc)
            5'd0:  id_skip_next = b;
            5'd1:  palette_kind_next = b;
            5'd2:  image_kind_next = b;
            5'd12: width_reg_next[7:0] = b;
            5'd13: width_reg_next[15:8] = b;
            5'd14: height_reg_next[7:0] = b;
            5'd15: height_reg_next[15:8] = b;
            5'd16: bpp_next = b;
            5'd17: top_down_next = b[5];
            default: ;
          endcase
          cmd.top_down = top_down_next;
          if (hc != tga_pkg::HDR_LAST) begin
            hcnt_next = hc + 5'd1;
          end else begin
            hcnt_next = 5'd0;
            push = 1'b1;
            if (bad) begin
              phase_next = tga_pkg::PH_IDLE;
              cmd.kind = tga_pkg::KIND_HDR_BAD;
              cmd.last = 1'b1;
            end else begin
              cmd.kind = tga_pkg::KIND_HDR_OK;
              cmd.image_width = width_reg;
              cmd.image_height = height_reg;
              cmd.last = empty;
              is_run_next = 1'b0;
              packet_left_next = 8'd0;
              cidx_next = 2'd0;
              if (empty)
                phase_next = tga_pkg::PH_IDLE;
              else if (id_skip != 8'd0)
                phase_next = tga_pkg::PH_SKIP;
              else if (image_kind == tga_pkg::TYPE_RAW)
                phase_next = tga_pkg::PH_COLOUR;
              else
                phase_next = tga_pkg::PH_PACKET;
            end
          end
        end
        tga_pkg::PH_SKIP: begin
          id_skip_next = id_skip - 8'd1;
          if (id_skip == 8'd1) begin
            is_run_next = 1'b0;
            packet_left_next = 8'd0;
            cidx_next = 2'd0;
            phase_next = (image_kind == tga_pkg::TYPE_RAW) ? tga_pkg::PH_COLOUR
                                                           : tga_pkg::PH_PACKET;
          end
        end
        tga_pkg::PH_PACKET: begin
          is_run_next = b[7];
          packet_left_next = {1'b0, b[6:0]} + 8'd1;
          cidx_next = 2'd0;
          phase_next = tga_pkg::PH_COLOUR;
        end
        tga_pkg::PH_COLOUR: begin
          if (cidx == 2'd0) gather_next[7:0] = b;
          if (cidx == 2'd1) gather_next[15:8] = b;
          if ((need4 && cidx != 2'd3) || (!need4 && cidx != 2'd2)) begin
            cidx_next = cidx + 2'd1;
          end else begin
            cidx_next = 2'd0;
            push = 1'b1;
            cmd.kind = tga_pkg::KIND_SPAN;
            cmd.blue = gather[7:0];
            cmd.green = gather[15:8];
            cmd.red = need4 ? red_hold : b;
            cmd.alpha = need4 ? b : tga_pkg::ALPHA_OPAQUE;
            cmd.span_count = is_run ? packet_left : 8'd1;
            if (image_kind == tga_pkg::TYPE_RLE) begin
              if (is_run) begin
                phase_next = tga_pkg::PH_PACKET;
              end else begin
                packet_left_next = packet_left - 8'd1;
                if (packet_left == 8'd1) phase_next = tga_pkg::PH_PACKET;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase_next == tga_pkg::PH_COLOUR && phase == tga_pkg::PH_COLOUR &&
        cidx == 2'd2)
      red_hold <= feed.data_byte;
    if (hcnt == 5'd16) area <= width_reg * height_reg;
    id_skip <= id_skip_next;
    image_kind <= image_kind_next;
    palette_kind <= palette_kind_next;
    bpp <= bpp_next;
    top_down <= top_down_next;
    width_reg <= width_reg_next;
    height_reg <= height_reg_next;
    is_run <= is_run_next;
    packet_left <= packet_left_next;
    gather <= gather_next;
    if (rst) begin
      phase <= tga_pkg::PH_IDLE;
      hcnt <= 5'd0;
      cidx <= 2'd0;
    end else begin
      phase <= phase_next;
      hcnt <= hcnt_next;
      cidx <= cidx_next;
    end
  end

endmodule

// ===== src/tga_queue.sv =====
// Small command queue between parser and span placer.
// Holds tga_pkg::cmd_t entries in flops; full when DEPTH entries wait.
module tga_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tga_pkg::cmd_t wdata,
  input  logic          pop,
  output logic          nonempty,
  output logic          full,
  output tga_pkg::cmd_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tga_pkg::cmd_t entry [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign nonempty = (fill != '0);
  assign full = (fill == CW'(DEPTH));
  assign rdata = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wdata;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

endmodule

// ===== src/tga_back.sv =====
// Span placer: tracks file row and column, clips at image end, flips rows.
// Takes tga_pkg::cmd_t from the queue and drives the result register.
module tga_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  tga_pkg::cmd_t         head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tga_pkg::result_item_t result
);

  logic        done, done_next;
  logic        busy, busy_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        top_down, top_down_next;
  logic [15:0] row, row_next;
  logic [15:0] col, col_next;
  logic [31:0] rem, rem_next;
  logic [16:0] divr, divr_next;
  logic [2:0]  divk, divk_next;
  logic        load;
  tga_pkg::result_item_t out_next;
  logic        out_free;

  assign out_free = !result_valid || !result_stall;
  assign pop = head_valid && !busy &&
               ((head.kind == tga_pkg::KIND_SPAN && done) || out_free);

  always_comb begin
    logic [7:0]  cnt;
    logic        lst;
    logic [16:0] pos;
    logic [16:0] wrap;
    logic [23:0] shifted;
    cnt = head.span_count;
    lst = 1'b0;
    pos = '0;
    wrap = '0;
    shifted = {8'd0, width_reg} << divk;
    done_next = done;
    busy_next = busy;
    width_reg_next = width_reg;
    height_reg_next = height_reg;
    top_down_next = top_down;
    row_next = row;
    col_next = col;
    rem_next = rem;
    divr_next = divr;
    divk_next = divk;
    load = 1'b0;
    out_next = result;
    if (busy) begin
      // one quotient bit per cycle, most significant first
      if ({7'd0, divr} >= shifted) begin
        divr_next = divr - shifted[16:0];
        row_next = row + (16'd1 << divk);
      end
      divk_next = divk - 3'd1;
      if (divk == 3'd0) begin
        busy_next = 1'b0;
        col_next = divr_next[15:0];
      end
    end else if (pop) begin
      case (head.kind)
        tga_pkg::KIND_SPAN: begin
          if (!done) begin
            if ({24'd0, head.span_count} >= rem) begin
              cnt = rem[7:0];
              lst = 1'b1;
            end
            load = 1'b1;
            out_next = '0;
            out_next.kind = tga_pkg::KIND_SPAN;
            out_next.red = head.red;
            out_next.green = head.green;
            out_next.blue = head.blue;
            out_next.alpha = head.alpha;
            out_next.span_count = cnt;
            out_next.dest_row = top_down ? row : (height_reg - 16'd1 - row);
            out_next.dest_column = col;
            out_next.last = lst;
            rem_next = rem - {24'd0, cnt};
            done_next = lst;
            pos = {1'b0, col} + {9'd0, cnt};
            wrap = pos - {1'b0, width_reg};
            if (!lst) begin
              if (pos < {1'b0, width_reg}) begin
                col_next = pos[15:0];
              end else if (wrap < {1'b0, width_reg}) begin
                row_next = row + 16'd1;
                col_next = wrap[15:0];
              end else begin
                busy_next = 1'b1;
                divr_next = pos;
                divk_next = 3'd7;
              end
            end
          end
        end
        default: begin
          load = 1'b1;
          out_next = '0;
          out_next.kind = head.kind;
          out_next.image_width = head.image_width;
          out_next.image_height = head.image_height;
          out_next.last = head.last;
          width_reg_next = head.image_width;
          height_reg_next = head.image_height;
          top_down_next = head.top_down;
          row_next = 16'd0;
          col_next = 16'd0;
          rem_next = head.area;
          done_next = head.last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    width_reg <= width_reg_next;
    height_reg <= height_reg_next;
    top_down <= top_down_next;
    row <= row_next;
    col <= col_next;
    rem <= rem_next;
    divr <= divr_next;
    divk <= divk_next;
    if (load) result <= out_next;
    if (rst) begin
      done <= 1'b1;
      busy <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      done <= done_next;
      busy <= busy_next;
      if (load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !pop)
    else $error("queue popped during row wrap");
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == tga_pkg::KIND_SPAN |-> result.span_count != 8'd0)
    else $error("empty span emitted");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    load && out_next.last |=> done)
    else $error("image end not recorded");
`endif

endmodule

// ===== src/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA 24/32-bit true-colour decoder.
// Instantiates tga_front, tga_queue and tga_back; types from tga_pkg.
//
// Usage: file bytes enter on feed (feed_valid/feed_stall), one item per
// cycle; start_of_file marks header byte 0 and restarts the parser at once.
// Results leave on result (result_valid/result_stall): a header verdict
// (accepted with size, or rejected) and then one span per raw pixel or
// run packet, with the destination row flipped for bottom-up images.
// Each result is held in the command queue and then in the result register.
// Throughput: one byte per cycle while feed_stall is low and spans wrap the
// row at most once. A span that wraps the row more than once (images
// narrower than the span) keeps the span placer busy while it divides, one
// quotient bit per cycle; the queue of QUEUE_DEPTH commands absorbs an isolated
// one, but such spans outpacing the divider fill it and feed_stall rises.
// When result_stall is high the result register holds and the queue fills;
// feed_stall rises only when the queue is full.
// Reset empties the queue and result register; bytes are ignored until a
// start_of_file item arrives. Bytes after the image end are dropped.
module tga_rle_pixel_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  feed_valid,
  output logic                  feed_stall,
  input  tga_pkg::feed_item_t   feed,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tga_pkg::result_item_t result
);

  logic          take;
  logic          push;
  tga_pkg::cmd_t cmd;
  logic          q_nonempty;
  logic          q_full;
  logic          q_pop;
  tga_pkg::cmd_t q_head;

  assign feed_stall = q_full;
  assign take = feed_valid && !q_full;

  tga_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .feed (feed),
    .push (push),
    .cmd  (cmd)
  );

  tga_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (cmd),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .full     (q_full),
    .rdata    (q_head)
  );

  tga_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_nonempty),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/tga_rle_pixel_decoder_unit_test.sv =====
// Self-checking bench for the TGA 24/32-bit true-colour decoder: streams whole
// files (good, rejected, truncated) and checks every result item in order.
// Depends on tga_pkg and tga_rle_pixel_decoder_unit.
module tga_rle_pixel_decoder_unit_test;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  feed_valid = 1'b0;
  logic                  feed_stall;
  tga_pkg::feed_item_t   feed = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  tga_pkg::result_item_t result;

  tga_rle_pixel_decoder_unit u_top (
    .clk(clk), .rst(rst),
    .feed_valid(feed_valid), .feed_stall(feed_stall), .feed(feed),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  // decoder state mirrored by the predictor
  logic [2:0]  ph;
  logic [4:0]  hdr_cnt;
  logic [7:0]  id_left, img_type, map_type, bpp;
  logic        flip_off;
  logic [15:0] wid, hgt, frow, fcol;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  col_idx;
  logic [31:0] gather;

  tga_pkg::feed_item_t   pending_bytes[$];
  tga_pkg::result_item_t expected_results[$];
  int cycle_count = 0, mismatches = 0, results_seen = 0, spans_seen = 0;
  int images_sent = 0;
  bit stimulus_done = 0, pause_req = 0;
  localparam int CYCLE_LIMIT = 400000;

  task automatic clear_decoder();
    ph = tga_pkg::PH_IDLE; hdr_cnt = '0; id_left = '0; img_type = '0; map_type = '0;
    bpp = '0; flip_off = 0; wid = '0; hgt = '0; frow = '0; fcol = '0;
    pkt_left = '0; pkt_run = 0; col_idx = '0; gather = '0;
  endtask

  task automatic start_pixels();
    pkt_run = 0; pkt_left = '0; col_idx = '0;
    ph = (img_type == tga_pkg::TYPE_RAW) ? tga_pkg::PH_COLOUR : tga_pkg::PH_PACKET;
  endtask

  task automatic predict_byte(input tga_pkg::feed_item_t it);
    tga_pkg::result_item_t r;
    logic [7:0] b;
    int need, cnt;
    longint remaining;
    int pos;
    b = it.data_byte;
    r = '0;
    if (it.start_of_file) begin
      clear_decoder();
      ph = tga_pkg::PH_HEADER;
    end
    case (ph)
      tga_pkg::PH_HEADER: begin
        case (hdr_cnt)
          5'd0: id_left = b;
          5'd1: map_type = b;
          5'd2: img_type = b;
          5'd12: wid[7:0] = b;
          5'd13: wid[15:8] = b;
          5'd14: hgt[7:0] = b;
          5'd15: hgt[15:8] = b;
          5'd16: bpp = b;
          5'd17: flip_off = b[5];
          default: ;
        endcase
        if (hdr_cnt < tga_pkg::HDR_LAST) begin
          hdr_cnt++;
        end else begin
          hdr_cnt = '0;
          r.last = 1'b1;
          if ((img_type != tga_pkg::TYPE_RAW && img_type != tga_pkg::TYPE_RLE) ||
              map_type != 0 ||
              (bpp != tga_pkg::BPP_24 && bpp != tga_pkg::BPP_32)) begin
            ph = tga_pkg::PH_IDLE;
            r.kind = tga_pkg::KIND_HDR_BAD;
          end else begin
            frow = '0; fcol = '0;
            r.kind = tga_pkg::KIND_HDR_OK; r.image_width = wid; r.image_height = hgt;
            if (wid == 0 || hgt == 0) ph = tga_pkg::PH_IDLE;
            else begin
              r.last = 1'b0;
              if (id_left != 0) ph = tga_pkg::PH_SKIP;
              else start_pixels();
            end
          end
          expected_results.push_back(r);
        end
      end
      tga_pkg::PH_SKIP: begin
        id_left--;
        if (id_left == 0) start_pixels();
      end
      tga_pkg::PH_PACKET: begin
        pkt_run = b[7];
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        col_idx = '0;
        ph = tga_pkg::PH_COLOUR;
      end
      tga_pkg::PH_COLOUR: begin
        need = (bpp == tga_pkg::BPP_32) ? 4 : 3;
        if (col_idx == 0) gather = '0;
        gather |= 32'(b) << (8 * col_idx);
        if (col_idx + 1 < need) begin
          col_idx++;
        end else begin
          col_idx = '0;
          r.kind = tga_pkg::KIND_SPAN;
          r.blue = gather[7:0]; r.green = gather[15:8]; r.red = gather[23:16];
          r.alpha = (need == 4) ? gather[31:24] : tga_pkg::ALPHA_OPAQUE;
          cnt = pkt_run ? pkt_left : 1;
          remaining = longint'(hgt - frow) * wid - fcol;
          if (cnt >= remaining) begin
            cnt = int'(remaining);
            r.last = 1'b1;
          end
          r.span_count = 8'(cnt);
          r.dest_row = flip_off ? frow : 16'(hgt - 16'd1 - frow);
          r.dest_column = fcol;
          expected_results.push_back(r);
          if (r.last) ph = tga_pkg::PH_IDLE;
          else begin
            pos = fcol + cnt;
            frow = frow + 16'(pos / wid);
            fcol = 16'(pos % wid);
            if (img_type == tga_pkg::TYPE_RLE) begin
              if (pkt_run) ph = tga_pkg::PH_PACKET;
              else begin
                pkt_left--;
                if (pkt_left == 0) ph = tga_pkg::PH_PACKET;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sof = 1'b0);
    tga_pkg::feed_item_t it;
    it.data_byte = b;
    it.start_of_file = sof;
    pending_bytes.push_back(it);
  endtask

  // header: id length, colour map, type, size, depth, descriptor, id bytes
  task automatic push_header(input logic [7:0] idl, input logic [7:0] cmap,
                             input logic [7:0] typ, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth,
                             input logic [7:0] desc);
    push_byte(idl, 1'b1);
    push_byte(cmap);
    push_byte(typ);
    for (int i = 3; i < 12; i++) push_byte(8'($urandom));
    push_byte(w[7:0]); push_byte(w[15:8]);
    push_byte(h[7:0]); push_byte(h[15:8]);
    push_byte(depth); push_byte(desc);
    for (int i = 0; i < idl; i++) push_byte(8'($urandom));
  endtask

  task automatic push_pixel(input int nb);
    for (int i = 0; i < nb; i++) push_byte(8'($urandom));
  endtask

  // well-formed image with random content; pixel data may overrun the image end
  task automatic push_image(input logic [7:0] typ, input logic [7:0] depth,
                            input logic [15:0] w, input logic [15:0] h,
                            input int trail);
    int total, left, n, nb;
    logic [7:0] pk;
    nb = depth / 8;
    push_header(8'($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0), 8'd0,
                typ, w, h, depth, 8'($urandom));
    total = w * h + $urandom_range(0, 3);
    left = total;
    while (left > 0) begin
      if (typ == tga_pkg::TYPE_RAW) begin
        push_pixel(nb); left--;
      end else begin
        pk = 8'($urandom);
        n = pk[6:0] + 1;
        push_byte(pk);
        if (pk[7]) push_pixel(nb);
        else for (int i = 0; i < n; i++) push_pixel(nb);
        left -= n;
      end
    end
    for (int i = 0; i < trail; i++) push_byte(8'($urandom));
    images_sent++;
  endtask

  // driver: bursts of valid with random gaps; holds payload while stalled
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (feed_valid && !feed_stall) begin
        predict_byte(feed);
        void'(pending_bytes.pop_front());
      end
      if (!(feed_valid && feed_stall)) begin
        if (pending_bytes.size() > 0 && !pause_req && gap_left == 0 &&
            !(feed_valid && !feed_stall && pending_bytes.size() == 0)) begin
          feed_valid <= 1'b1;
          feed <= pending_bytes[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          feed_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver stall pattern and result checking
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (result.kind == tga_pkg::KIND_SPAN) spans_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", result);
        end else begin
          if (result !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_results[0], result);
          end
          void'(expected_results.pop_front());
        end
      end
      if (cycle_count % 512 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= (cycle_count % 7 < 4);
        default: result_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    clear_decoder();
    // directed: bytes before any start, rejects, empty images, tiny images
    push_byte(8'hff); push_byte(8'h00);
    push_header(8'd0, 8'd1, tga_pkg::TYPE_RAW, 16'd2, 16'd2, tga_pkg::BPP_24, 8'h00);
    push_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, tga_pkg::BPP_24, 8'h00);
    push_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd2, 16'd2, 8'd16, 8'h00);
    push_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd0, 16'hffff, tga_pkg::BPP_32, 8'h00);
    push_header(8'd0, 8'd0, tga_pkg::TYPE_RAW, 16'hffff, 16'd0, tga_pkg::BPP_32, 8'h20);
    push_image(tga_pkg::TYPE_RAW, tga_pkg::BPP_24, 16'd2, 16'd2, 2);
    push_image(tga_pkg::TYPE_RLE, tga_pkg::BPP_32, 16'd3, 16'd2, 1);
    push_header(8'd255, 8'd0, tga_pkg::TYPE_RLE, 16'hffff, 16'hffff, tga_pkg::BPP_32,
                8'hff);
    push_byte(8'hff); push_pixel(4); push_byte(8'h80); push_pixel(4);
    // restart mid-image
    push_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd1, 16'd200, tga_pkg::BPP_24, 8'h00);
    push_byte(8'hfe); push_pixel(3);
    while (pending_bytes.size() < 1850) begin
      case ($urandom_range(0, 9))
        0: push_header(8'($urandom), 8'($urandom_range(0, 1)), 8'($urandom_range(0, 11)),
                       16'($urandom), 16'($urandom), 8'($urandom_range(0, 1) ? 24 : 32),
                       8'($urandom));
        1: for (int i = 0; i < 5; i++) push_byte(8'($urandom));
        default: push_image($urandom_range(0, 1) ? tga_pkg::TYPE_RAW : tga_pkg::TYPE_RLE,
                            $urandom_range(0, 1) ? tga_pkg::BPP_24 : tga_pkg::BPP_32,
                            16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                            $urandom_range(0, 3));
      endcase
      if (pending_bytes.size() > 900 && pending_bytes.size() < 1000) begin
        push_image(tga_pkg::TYPE_RLE, tga_pkg::BPP_32, 16'd4, 16'd3, 0);
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // pause the sender once until the decoder has drained
    wait (pending_bytes.size() < 1000);
    @(posedge clk);
    pause_req <= 1'b1;
    wait (!feed_valid && expected_results.size() == 0);
    repeat (4) @(posedge clk);
    wait (expected_results.size() == 0);
    pause_req <= 1'b0;
    wait (pending_bytes.size() == 0 && !feed_valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    stimulus_done = 1;
  end

  always @(posedge clk) begin
    if (stimulus_done) begin
      $display("%0d images streamed, %0d result items checked (%0d spans)",
               images_sent, results_seen, spans_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("%0d mismatches, %0d results outstanding", mismatches,
                 expected_results.size());
        $display("Verification failed");
      end
      $finish;
    end else if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Verification failed");
      $finish;
    end
  end
endmodule

// ===== tga_rle_pixel_decoder_unit.f =====
src/tga_pkg.sv
src/tga_front.sv
src/tga_queue.sv
src/tga_back.sv
src/tga_rle_pixel_decoder_unit.sv
verif/tga_rle_pixel_decoder_unit_test.sv
